// ===== hw/rtl/swrv_pkg.sv =====
// ----------------------------------------------------------------------------
// swrv_pkg
// Shared field widths, command and status codes, and cell control bundle
// for the stack with remove-by-value.
// ----------------------------------------------------------------------------
package swrv_pkg;

    localparam int CMD_W     = 2;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 7;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_EMPTY     = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic cmp;
        logic push;
        logic pop;
        logic rm;
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/swrv_cell.sv =====
// ----------------------------------------------------------------------------
// swrv_cell
// One stack slot: holds a word, flags a key match, and shifts with its
// neighbors on push, pop and remove.
// ----------------------------------------------------------------------------
module swrv_cell #(
    parameter int WIDTH = 32,
    parameter int CNT_W = 7,
    parameter int IDX   = 0
) (
    input  logic                aclk,
    input  swrv_pkg::cell_ctrl_t ctrl,
    input  logic [CNT_W-1:0]    count,
    input  logic [WIDTH-1:0]    cmp_key,
    input  logic [WIDTH-1:0]    upper_word,
    input  logic [WIDTH-1:0]    lower_word,
    input  logic                hit_at_or_above,
    output logic [WIDTH-1:0]    word,
    output logic                match
);

    logic [WIDTH-1:0] word_reg;
    logic [WIDTH-1:0] word_next;
    logic             match_reg;
    logic             match_next;
    logic             in_use;

    assign in_use = CNT_W'(IDX) < count;

    always_comb begin
        word_next  = word_reg;
        match_next = match_reg;
        if (ctrl.cmp) begin
            match_next = in_use && (word_reg == cmp_key);
        end
        priority if (ctrl.push) begin
            word_next = upper_word;
        end else if (ctrl.pop) begin
            word_next = lower_word;
        end else if (ctrl.rm && hit_at_or_above) begin
            word_next = lower_word;
        end else begin
            word_next = word_reg;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg  <= word_next;
        match_reg <= match_next;
    end

    assign word  = word_reg;
    assign match = match_reg;

endmodule

// ===== hw/rtl/swrv_prefix_or.sv =====
// ----------------------------------------------------------------------------
// swrv_prefix_or
// Log-depth inclusive prefix OR over the cell match flags, from the top
// of the stack downward.
// ----------------------------------------------------------------------------
module swrv_prefix_or #(
    parameter int N = 64
) (
    input  logic [N-1:0] match,
    output logic [N-1:0] hit_at_or_above
);

    localparam int LEVELS = (N > 1) ? $clog2(N) : 1;

    logic [N-1:0] lvl [LEVELS+1];

    assign lvl[0] = match;

    for (genvar l = 0; l < LEVELS; l++) begin : g_level
        for (genvar i = 0; i < N; i++) begin : g_bit
            if (i >= (1 << l)) begin : g_or
                assign lvl[l+1][i] = lvl[l][i] | lvl[l][i-(1<<l)];
            end else begin : g_pass
                assign lvl[l+1][i] = lvl[l][i];
            end
        end
    end

    assign hit_at_or_above = lvl[LEVELS];

endmodule

// ===== hw/rtl/stack_with_remove_by_value_core.sv =====
// ----------------------------------------------------------------------------
// stack_with_remove_by_value_core
// Bounded LIFO stack with push, pop and remove of the topmost matching word,
// built as a row of shifting cells with the top of stack in cell 0.
//
// Channel  Dir  tdata (low bit up)                       tuser
// s_       in   value[31:0]                              command[1:0]
// m_       out  popped_value[31:0], entry_count[38:32]   status[1:0]
//
// A transaction runs in an accept step and an execute step: the accept edge
// latches the command and loads every cell's compare flag, and the execute
// step shifts the cell row and writes the result register. A waiting result
// holds the execute step but not the accept of the next transaction. Reset
// empties the stack at once; cell contents are not cleared.
// ----------------------------------------------------------------------------
module stack_with_remove_by_value_core #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [swrv_pkg::S_TDATA_W-1:0]     s_tdata,   // value
    input  logic [swrv_pkg::CMD_W-1:0]         s_tuser,   // command
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [swrv_pkg::M_TDATA_W-1:0]     m_tdata,   // popped_value, entry_count
    output logic [swrv_pkg::STATUS_W-1:0]      m_tuser    // status
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t                         state_reg;
    logic [CNT_W-1:0]               count_reg;
    logic [CNT_W-1:0]               count_next;
    swrv_pkg::cmd_t                 cmd_reg;
    logic [WIDTH-1:0]               key_reg;
    logic                           m_tvalid_reg;
    swrv_pkg::status_t              status_reg;
    swrv_pkg::status_t              status_next;
    logic [swrv_pkg::VALUE_W-1:0]   popped_reg;
    logic [swrv_pkg::VALUE_W-1:0]   popped_next;
    logic [swrv_pkg::COUNT_W-1:0]   count_out_reg;

    logic                           s_accept;
    logic                           do_op;
    logic [WIDTH-1:0]               in_key;
    swrv_pkg::cell_ctrl_t           ctrl;
    logic [WIDTH-1:0]               cell_word [DEPTH];
    logic [DEPTH-1:0]               cell_match;
    logic [DEPTH-1:0]               hit_at_or_above;
    logic                           any_hit;
    logic                           not_full;
    logic                           not_empty;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign do_op    = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);
    assign in_key   = WIDTH'($signed(s_tdata[swrv_pkg::VALUE_W-1:0]));

    assign not_full  = count_reg < CNT_W'(DEPTH);
    assign not_empty = count_reg != '0;
    assign any_hit   = hit_at_or_above[DEPTH-1];

    always_comb begin
        ctrl.cmp  = s_accept;
        ctrl.push = do_op && (cmd_reg == swrv_pkg::CMD_PUSH) && not_full;
        ctrl.pop  = do_op && (cmd_reg == swrv_pkg::CMD_POP) && not_empty;
        ctrl.rm   = do_op && (cmd_reg == swrv_pkg::CMD_REMOVE) && any_hit;
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [WIDTH-1:0] upper_word;
        logic [WIDTH-1:0] lower_word;

        if (i == 0) begin : g_top
            assign upper_word = key_reg;
        end else begin : g_mid_up
            assign upper_word = cell_word[i-1];
        end

        if (i == DEPTH - 1) begin : g_bottom
            assign lower_word = cell_word[i];
        end else begin : g_mid_down
            assign lower_word = cell_word[i+1];
        end

        swrv_cell #(
            .WIDTH (WIDTH),
            .CNT_W (CNT_W),
            .IDX   (i)
        ) u_cell (
            .aclk            (aclk),
            .ctrl            (ctrl),
            .count           (count_reg),
            .cmp_key         (in_key),
            .upper_word      (upper_word),
            .lower_word      (lower_word),
            .hit_at_or_above (hit_at_or_above[i]),
            .word            (cell_word[i]),
            .match           (cell_match[i])
        );
    end

    swrv_prefix_or #(
        .N (DEPTH)
    ) u_prefix (
        .match           (cell_match),
        .hit_at_or_above (hit_at_or_above)
    );

    always_comb begin
        count_next  = count_reg;
        status_next = swrv_pkg::STATUS_OK;
        popped_next = '0;
        unique case (cmd_reg)
            swrv_pkg::CMD_PUSH: begin
                if (not_full) begin
                    count_next = count_reg + 1'b1;
                end else begin
                    status_next = swrv_pkg::STATUS_FULL;
                end
            end
            swrv_pkg::CMD_POP: begin
                if (not_empty) begin
                    count_next  = count_reg - 1'b1;
                    popped_next = swrv_pkg::VALUE_W'(cell_word[0]);
                end else begin
                    status_next = swrv_pkg::STATUS_EMPTY;
                end
            end
            swrv_pkg::CMD_REMOVE: begin
                if (any_hit) begin
                    count_next = count_reg - 1'b1;
                end else begin
                    status_next = swrv_pkg::STATUS_NOT_FOUND;
                end
            end
            default: begin
                status_next = swrv_pkg::STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (do_op) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (do_op) begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg <= swrv_pkg::cmd_t'(s_tuser);
            key_reg <= in_key;
        end
        if (do_op) begin
            status_reg    <= status_next;
            popped_reg    <= popped_next;
            count_out_reg <= swrv_pkg::COUNT_W'(count_next);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {{(swrv_pkg::M_TDATA_W - swrv_pkg::VALUE_W - swrv_pkg::COUNT_W){1'b0}},
                       count_out_reg, popped_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.pop |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not drop the entry count by one");

    a_remove_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.rm |=> (m_tvalid && (m_tuser == swrv_pkg::STATUS_OK)))
        else $error("remove with a hit did not report ok");

    a_full_only_at_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_op && (status_next == swrv_pkg::STATUS_FULL)) |-> (count_reg == CNT_W'(DEPTH)))
        else $error("full reported below depth");

endmodule
